// ----- rtl/hsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hsa_pkg
// types, microcode encoding and control store for the heap sort array
// ----------------------------------------------------------------------------
package hsa_pkg;

	localparam int DATA_W = 32;

	// sequencer steps, in control-store order (fall-through is pc + 1)
	typedef enum logic [4:0] {
		ST_LOAD,
		ST_BINIT,
		ST_BTEST,
		ST_SIFT0,
		ST_SIFT1,
		ST_SIFTL,
		ST_SIFTLR,
		ST_SIFTR,
		ST_SIFTC,
		ST_SIFTW,
		ST_EINIT,
		ST_ETEST,
		ST_EXA,
		ST_EXB,
		ST_EXC,
		ST_OINIT,
		ST_OCHK,
		ST_ORD,
		ST_OWR
	} step_t;

	typedef enum logic [2:0] {
		AD_CNT, AD_CUR, AD_L, AD_R, AD_BIG, AD_ZERO, AD_I, AD_K
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_IN, WD_RDATA, WD_BIGV, WD_CURV
	} wd_sel_t;

	typedef enum logic [3:0] {
		ACT_NONE, ACT_LOAD, ACT_BINIT, ACT_BDEC, ACT_CURV, ACT_SETBIG, ACT_CMPL,
		ACT_CMPR, ACT_STEP, ACT_EINIT, ACT_EXC, ACT_OINIT, ACT_OUT
	} act_t;

	typedef enum logic [3:0] {
		CD_NEXT, CD_JUMP, CD_WAIT_IN, CD_IZERO, CD_LGE, CD_RGE, CD_BIGCUR,
		CD_KEND, CD_STALL
	} cond_t;

	// one control word
	typedef struct packed {
		addr_sel_t addr;
		logic      rd;
		logic      wr;
		wd_sel_t   wd;
		act_t      act;
		cond_t     cond;
		logic      to_ret;
		step_t     target;
	} ctrl_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic set_end;
		logic izero;
		logic lge;
		logic rge;
		logic bigcur;
		logic kend;
		logic slot_free;
		logic phase_ext;
	} status_t;

	// control store: addr, rd, wr, wd, act, cond, to_ret, target
	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		unique case (s)
			ST_LOAD:   c = '{AD_CNT,  1'b0, 1'b1, WD_IN,    ACT_LOAD,   CD_WAIT_IN, 1'b0, ST_LOAD};
			ST_BINIT:  c = '{AD_CUR,  1'b0, 1'b0, WD_IN,    ACT_BINIT,  CD_NEXT,    1'b0, ST_LOAD};
			ST_BTEST:  c = '{AD_CUR,  1'b0, 1'b0, WD_IN,    ACT_BDEC,   CD_IZERO,   1'b0, ST_EINIT};
			ST_SIFT0:  c = '{AD_CUR,  1'b1, 1'b0, WD_IN,    ACT_NONE,   CD_NEXT,    1'b0, ST_LOAD};
			ST_SIFT1:  c = '{AD_CUR,  1'b0, 1'b0, WD_IN,    ACT_CURV,   CD_NEXT,    1'b0, ST_LOAD};
			ST_SIFTL:  c = '{AD_L,    1'b1, 1'b0, WD_IN,    ACT_SETBIG, CD_LGE,     1'b1, ST_LOAD};
			ST_SIFTLR: c = '{AD_R,    1'b1, 1'b0, WD_IN,    ACT_CMPL,   CD_RGE,     1'b0, ST_SIFTC};
			ST_SIFTR:  c = '{AD_CUR,  1'b0, 1'b0, WD_IN,    ACT_CMPR,   CD_NEXT,    1'b0, ST_LOAD};
			ST_SIFTC:  c = '{AD_CUR,  1'b0, 1'b1, WD_BIGV,  ACT_NONE,   CD_BIGCUR,  1'b1, ST_LOAD};
			ST_SIFTW:  c = '{AD_BIG,  1'b0, 1'b1, WD_CURV,  ACT_STEP,   CD_JUMP,    1'b0, ST_SIFTL};
			ST_EINIT:  c = '{AD_CUR,  1'b0, 1'b0, WD_IN,    ACT_EINIT,  CD_NEXT,    1'b0, ST_LOAD};
			ST_ETEST:  c = '{AD_ZERO, 1'b1, 1'b0, WD_IN,    ACT_NONE,   CD_IZERO,   1'b0, ST_OINIT};
			ST_EXA:    c = '{AD_I,    1'b1, 1'b0, WD_IN,    ACT_CURV,   CD_NEXT,    1'b0, ST_LOAD};
			ST_EXB:    c = '{AD_ZERO, 1'b0, 1'b1, WD_RDATA, ACT_NONE,   CD_NEXT,    1'b0, ST_LOAD};
			ST_EXC:    c = '{AD_I,    1'b0, 1'b1, WD_CURV,  ACT_EXC,    CD_JUMP,    1'b0, ST_SIFT0};
			ST_OINIT:  c = '{AD_K,    1'b0, 1'b0, WD_IN,    ACT_OINIT,  CD_NEXT,    1'b0, ST_LOAD};
			ST_OCHK:   c = '{AD_K,    1'b0, 1'b0, WD_IN,    ACT_NONE,   CD_KEND,    1'b0, ST_LOAD};
			ST_ORD:    c = '{AD_K,    1'b1, 1'b0, WD_IN,    ACT_NONE,   CD_STALL,   1'b0, ST_ORD};
			ST_OWR:    c = '{AD_K,    1'b0, 1'b0, WD_IN,    ACT_OUT,    CD_JUMP,    1'b0, ST_OCHK};
			default:   c = '{AD_CNT,  1'b0, 1'b0, WD_IN,    ACT_NONE,   CD_JUMP,    1'b0, ST_LOAD};
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/hsa_ram.sv -----
// ----------------------------------------------------------------------------
// hsa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/hsa_seq.sv -----
// ----------------------------------------------------------------------------
// hsa_seq
// microcode sequencer: step counter, control store lookup, conditional jumps
// ----------------------------------------------------------------------------
module hsa_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  hsa_pkg::status_t st,
	output hsa_pkg::step_t   pc,
	output hsa_pkg::ctrl_t   cw
);
	import hsa_pkg::*;

	step_t pc_q;
	ctrl_t cw_w;
	logic  taken;
	step_t ret_w;
	step_t next_w;

	assign cw_w  = ucode(pc_q);
	assign ret_w = st.phase_ext ? ST_ETEST : ST_BTEST;

	always_comb begin
		case (cw_w.cond)
			CD_NEXT:    taken = 1'b0;
			CD_JUMP:    taken = 1'b1;
			CD_WAIT_IN: taken = !st.set_end;
			CD_IZERO:   taken = st.izero;
			CD_LGE:     taken = st.lge;
			CD_RGE:     taken = st.rge;
			CD_BIGCUR:  taken = st.bigcur;
			CD_KEND:    taken = st.kend;
			CD_STALL:   taken = !st.slot_free;
			default:    taken = 1'b0;
		endcase
	end

	always_comb begin
		if (taken) begin
			next_w = cw_w.to_ret ? ret_w : cw_w.target;
		end else begin
			next_w = step_t'(5'(pc_q + 5'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_LOAD;
		end else begin
			pc_q <= next_w;
		end
	end

	assign pc = pc_q;
	assign cw = cw_w;

endmodule

// ----- rtl/heap_sort_array.sv -----
// ----------------------------------------------------------------------------
// heap_sort_array
// heapsort of one set of signed 32-bit values, microcoded
// ----------------------------------------------------------------------------
// the block takes a set of up to SIZE signed values, one per input transfer;
// a transfer with tlast set, or the SIZE-th transfer, closes the set. the
// values are then heap-sorted in place (max-heap build by sift-down, then
// root/end swaps with sift-down over the shrinking heap) and streamed out in
// ascending order, tlast on the largest. loading takes one value per cycle.
// sorting runs on one single-port-read element ram driven by a microcode
// sequencer: a full sift level steps through read left, read right and
// compare left, compare right and two writes, after a read and a load of
// the node at the start of a sift. each result passes an index check, a
// ram read and an output load, and waits in the ram read step while the
// output register is held. the input is not ready while a set is being
// sorted or emitted; it is ready again once the index check after the last
// result finds the whole set emitted.
module heap_sort_array #(
	parameter int SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tlast,   // is_last
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sorted_value
	output logic        m_tlast    // last_out
);
	import hsa_pkg::*;

	localparam int AW = $clog2(SIZE);     // element address
	localparam int CW = $clog2(SIZE + 1); // counts up to SIZE
	localparam int LW = AW + 2;           // child index, up to 2*SIZE

	// sequencer
	step_t   pc;
	ctrl_t   cw;
	status_t st;

	// datapath registers
	logic [CW-1:0]            cnt_q;   // values loaded so far
	logic [CW-1:0]            len_q;   // set length
	logic [CW-1:0]            hlen_q;  // current heap length
	logic [CW-1:0]            k_q;     // output index
	logic [AW-1:0]            i_q;     // build / extract loop index
	logic [AW-1:0]            cur_q;   // node being sifted
	logic [AW-1:0]            big_q;   // largest of node and children
	logic                     phase_q; // 0 build, 1 extract
	logic signed [DATA_W-1:0] curv_q;  // value being sifted down
	logic signed [DATA_W-1:0] bigv_q;  // value at big_q

	// output register
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              m_tlast_q;

	// ram
	logic                     ram_we;
	logic                     ram_re;
	logic [AW-1:0]            ram_addr;
	logic [DATA_W-1:0]        ram_wdata;
	logic signed [DATA_W-1:0] ram_rdata;

	logic          in_xfer;
	logic          out_xfer;
	logic [LW-1:0] l_w;
	logic [LW-1:0] r_w;
	logic          rd_gt;

	hsa_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.pc     (pc),
		.cw     (cw)
	);

	hsa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// handshakes: input open only in the load step
	assign s_tready = (pc == ST_LOAD);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid_q && m_tready;

	// heap children of the current node
	assign l_w   = {1'b0, cur_q, 1'b1};
	assign r_w   = l_w + LW'(1);
	assign rd_gt = (ram_rdata > bigv_q);

	// element address select
	always_comb begin
		case (cw.addr)
			AD_CNT:  ram_addr = cnt_q[AW-1:0];
			AD_CUR:  ram_addr = cur_q;
			AD_L:    ram_addr = l_w[AW-1:0];
			AD_R:    ram_addr = r_w[AW-1:0];
			AD_BIG:  ram_addr = big_q;
			AD_ZERO: ram_addr = '0;
			AD_I:    ram_addr = i_q;
			AD_K:    ram_addr = k_q[AW-1:0];
			default: ram_addr = '0;
		endcase
	end

	// write data select
	always_comb begin
		case (cw.wd)
			WD_IN:    ram_wdata = s_tdata;
			WD_RDATA: ram_wdata = ram_rdata;
			WD_BIGV:  ram_wdata = bigv_q;
			WD_CURV:  ram_wdata = curv_q;
			default:  ram_wdata = s_tdata;
		endcase
	end

	// a load-step write only happens on an accepted transfer
	assign ram_we = cw.wr && ((cw.act != ACT_LOAD) || in_xfer);
	assign ram_re = cw.rd;

	// flags for the sequencer
	assign st.set_end   = in_xfer && (s_tlast || (cnt_q == CW'(SIZE - 1)));
	assign st.izero     = (i_q == '0);
	assign st.lge       = (l_w >= LW'(hlen_q));
	assign st.rge       = (r_w >= LW'(hlen_q));
	assign st.bigcur    = (big_q == cur_q);
	assign st.kend      = (k_q == len_q);
	assign st.slot_free = !m_tvalid_q || m_tready;
	assign st.phase_ext = phase_q;

	// control-state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			len_q      <= '0;
			hlen_q     <= '0;
			k_q        <= '0;
			i_q        <= '0;
			phase_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_xfer) begin
				m_tvalid_q <= 1'b0;
			end
			case (cw.act)
				ACT_LOAD: begin
					if (in_xfer) begin
						cnt_q <= cnt_q + CW'(1);
						len_q <= cnt_q + CW'(1);
					end
				end
				ACT_BINIT: begin
					i_q     <= AW'(len_q >> 1);
					hlen_q  <= len_q;
					phase_q <= 1'b0;
				end
				ACT_BDEC: begin
					if (i_q != '0) begin
						i_q <= i_q - AW'(1);
					end
				end
				ACT_EINIT: begin
					i_q     <= AW'(len_q - CW'(1));
					phase_q <= 1'b1;
				end
				ACT_EXC: begin
					hlen_q <= CW'(i_q);
					i_q    <= i_q - AW'(1);
				end
				ACT_OINIT: begin
					k_q   <= '0;
					cnt_q <= '0;
				end
				ACT_OUT: begin
					k_q        <= k_q + CW'(1);
					m_tvalid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// sift registers and output payload
	always_ff @(posedge clk) begin
		case (cw.act)
			ACT_BDEC: begin
				cur_q <= i_q - AW'(1);
			end
			ACT_CURV: begin
				curv_q <= ram_rdata;
			end
			ACT_SETBIG: begin
				big_q  <= cur_q;
				bigv_q <= curv_q;
			end
			ACT_CMPL: begin
				if (rd_gt) begin
					big_q  <= l_w[AW-1:0];
					bigv_q <= ram_rdata;
				end
			end
			ACT_CMPR: begin
				if (rd_gt) begin
					big_q  <= r_w[AW-1:0];
					bigv_q <= ram_rdata;
				end
			end
			ACT_STEP: begin
				cur_q <= big_q;
			end
			ACT_EXC: begin
				cur_q <= '0;
			end
			ACT_OUT: begin
				m_tdata_q <= ram_rdata;
				m_tlast_q <= (k_q == len_q - CW'(1));
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef NO_ASSERTIONS
	// the load counter never runs past the store
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc == ST_LOAD) |-> (cnt_q < CW'(SIZE)))
		else $error("load count beyond store depth");

	// a node being sifted always lies inside the current heap
	a_cur_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(pc == ST_SIFTL) |-> (LW'(cur_q) < LW'(hlen_q)))
		else $error("sift node outside heap");

	// a result is only loaded into an empty output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.act == ACT_OUT) |-> !m_tvalid_q)
		else $error("output register overwritten");

	// the final result of a set is followed by reopening the input
	a_last_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		((cw.act == ACT_OUT) && (k_q == len_q - CW'(1))) |=> ##1 s_tready)
		else $error("input not reopened after last result");
`endif

endmodule
